// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands used by the escape-time block. Each macro expects
// signals named clk and rst in the enclosing module.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define MBE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define MBE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/mbe_pkg.sv =====
// ----------------------------------------------------------------------------
// mbe_pkg
// Shared types, constants and the saturation helper of the escape-time block.
// ----------------------------------------------------------------------------
`default_nettype none

package mbe_pkg;

  // fixed point format of c and z
  localparam int FRAC_BITS = 28;
  // width of a squared term after the fraction shift
  localparam int SQ_W      = 64 - FRAC_BITS;
  // width of the doubled cross term after its shift
  localparam int XY_W      = 65 - FRAC_BITS;
  localparam int ACC_BASE  = (XY_W > 32) ? XY_W : 32;
  // accumulator wide enough for every sum and for the escape limit
  localparam int ACC_W     = ((ACC_BASE > FRAC_BITS + 3) ? ACC_BASE : FRAC_BITS + 3) + 2;

  localparam logic signed [ACC_W-1:0] LIMIT   = ACC_W'(1) << (FRAC_BITS + 2);
  localparam logic signed [ACC_W-1:0] SAT_MAX = ACC_W'(64'sd2147483647);
  localparam logic signed [ACC_W-1:0] SAT_MIN = ACC_W'(-64'sd2147483648);

  // APB address width: five registers at word spacing
  localparam int ADDR_W = 5;

  // register map, word index
  typedef enum logic [2:0] {
    REG_X_ORIGIN = 3'd0,
    REG_Y_TOP    = 3'd1,
    REG_X_STEP   = 3'd2,
    REG_Y_STEP   = 3'd3,
    REG_MAX_ITER = 3'd4
  } reg_idx_t;

  // register reset values
  localparam logic signed [31:0] X_ORIGIN_RST = 32'shD8000000;  // -2.5
  localparam logic signed [31:0] Y_TOP_RST    = 32'sh10000000;  // 1.0
  localparam logic [24:0]        X_STEP_RST   = 25'd917504;
  localparam logic [24:0]        Y_STEP_RST   = 25'd917726;
  localparam logic [15:0]        MAX_ITER_RST = 16'd1000;

  // configuration seen by the sequencer
  typedef struct packed {
    logic signed [31:0] x_origin;
    logic signed [31:0] y_top;
    logic [24:0]        x_step;
    logic [24:0]        y_step;
    logic [15:0]        max_iter;
  } cfg_t;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_X,
    ST_MUL_Y,
    ST_CI_WB,
    ST_SQ_X,
    ST_SQ_Y,
    ST_PROD,
    ST_UPD
  } state_t;

  // clamp a wide signed sum to the signed 32 bit range
  function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
    if (v > SAT_MAX) begin
      return 32'sh7FFFFFFF;
    end else if (v < SAT_MIN) begin
      return 32'sh80000000;
    end else begin
      return $signed(v[31:0]);
    end
  endfunction

endpackage

`default_nettype wire

// ===== rtl/mbe_mul.sv =====
// ----------------------------------------------------------------------------
// mbe_mul
// Shared signed 32x32 multiplier with a registered 64 bit product.
// ----------------------------------------------------------------------------
`default_nettype none

module mbe_mul (
  input  wire logic               clk,
  input  wire logic signed [31:0] a,
  input  wire logic signed [31:0] b,
  output logic signed [63:0]      p
);

  // product is registered: it lands in the cycle after the operands
  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule

`default_nettype wire

// ===== rtl/mbe_regs.sv =====
// ----------------------------------------------------------------------------
// mbe_regs
// APB register file holding the view window and the iteration limit.
// ----------------------------------------------------------------------------
`default_nettype none

module mbe_regs (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [mbe_pkg::ADDR_W-1:0] paddr,
  input  wire logic [31:0]                pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready,
  output mbe_pkg::cfg_t                   cfg
);

  logic               wr_en;
  mbe_pkg::reg_idx_t  idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = mbe_pkg::reg_idx_t'(paddr[mbe_pkg::ADDR_W-1:2]);

  // register writes; unmapped words are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.x_origin <= mbe_pkg::X_ORIGIN_RST;
      cfg.y_top    <= mbe_pkg::Y_TOP_RST;
      cfg.x_step   <= mbe_pkg::X_STEP_RST;
      cfg.y_step   <= mbe_pkg::Y_STEP_RST;
      cfg.max_iter <= mbe_pkg::MAX_ITER_RST;
    end else if (wr_en) begin
      case (idx)
        mbe_pkg::REG_X_ORIGIN: cfg.x_origin <= $signed(pwdata);
        mbe_pkg::REG_Y_TOP:    cfg.y_top    <= $signed(pwdata);
        mbe_pkg::REG_X_STEP:   cfg.x_step   <= pwdata[24:0];
        mbe_pkg::REG_Y_STEP:   cfg.y_step   <= pwdata[24:0];
        mbe_pkg::REG_MAX_ITER: cfg.max_iter <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    case (idx)
      mbe_pkg::REG_X_ORIGIN: prdata = cfg.x_origin;
      mbe_pkg::REG_Y_TOP:    prdata = cfg.y_top;
      mbe_pkg::REG_X_STEP:   prdata = {7'd0, cfg.x_step};
      mbe_pkg::REG_Y_STEP:   prdata = {7'd0, cfg.y_step};
      mbe_pkg::REG_MAX_ITER: prdata = {16'd0, cfg.max_iter};
      default:               prdata = 32'd0;
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/mbe_seq.sv =====
// ----------------------------------------------------------------------------
// mbe_seq
// Sequencer and datapath: maps the pixel to c, then runs z = z*z + c on the
// shared multiplier, three products per iteration.
// ----------------------------------------------------------------------------
`default_nettype none

module mbe_seq (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire mbe_pkg::cfg_t      cfg,
  input  wire logic               start,
  input  wire logic [9:0]         column,
  input  wire logic [9:0]         row,
  output logic                    busy,
  output logic                    done,
  output logic [15:0]             iterations,
  output logic signed [31:0]      c_real,
  output logic signed [31:0]      c_imag
);

  mbe_pkg::state_t state, state_next;

  // pixel and orbit registers
  logic [9:0]                         col_q;
  logic [9:0]                         row_q;
  logic [15:0]                        count;
  logic signed [31:0]                 cr;
  logic signed [31:0]                 ci;
  logic signed [31:0]                 zx;
  logic signed [31:0]                 zy;
  logic signed [mbe_pkg::SQ_W-1:0]    xx;
  logic signed [mbe_pkg::SQ_W-1:0]    yy;
  logic                               fin;

  // shared multiplier
  logic signed [31:0] mul_a;
  logic signed [31:0] mul_b;
  logic signed [63:0] prod;

  // datapath terms
  logic signed [mbe_pkg::SQ_W-1:0]  sq_val;
  logic signed [mbe_pkg::XY_W-1:0]  xy_val;
  logic signed [mbe_pkg::ACC_W-1:0] esc_sum;
  logic signed [mbe_pkg::ACC_W-1:0] zx_sum;
  logic signed [mbe_pkg::ACC_W-1:0] zy_sum;
  logic signed [mbe_pkg::ACC_W-1:0] cr_sum;
  logic signed [mbe_pkg::ACC_W-1:0] ci_sum;
  logic                             at_limit;
  logic                             escaped;

  mbe_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (prod)
  );

  // shifted products and sums
  assign sq_val   = mbe_pkg::SQ_W'(prod >>> mbe_pkg::FRAC_BITS);
  assign xy_val   = mbe_pkg::XY_W'(prod >>> (mbe_pkg::FRAC_BITS - 1));
  assign esc_sum  = mbe_pkg::ACC_W'(xx) + mbe_pkg::ACC_W'(sq_val);
  assign zx_sum   = mbe_pkg::ACC_W'(xx) - mbe_pkg::ACC_W'(yy) + mbe_pkg::ACC_W'(cr);
  assign zy_sum   = mbe_pkg::ACC_W'(xy_val) + mbe_pkg::ACC_W'(ci);
  assign cr_sum   = mbe_pkg::ACC_W'(cfg.x_origin) + mbe_pkg::ACC_W'(prod);
  assign ci_sum   = mbe_pkg::ACC_W'(cfg.y_top) - mbe_pkg::ACC_W'(prod);
  assign at_limit = (count >= cfg.max_iter);
  assign escaped  = (esc_sum >= mbe_pkg::LIMIT);

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mbe_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and multiplier operand select
  always_comb begin
    state_next = state;
    mul_a      = 32'sd0;
    mul_b      = 32'sd0;
    case (state)
      mbe_pkg::ST_IDLE: begin
        if (start && !fin) begin
          state_next = mbe_pkg::ST_MUL_X;
        end
      end
      mbe_pkg::ST_MUL_X: begin
        mul_a      = $signed({22'd0, col_q});
        mul_b      = $signed({7'd0, cfg.x_step});
        state_next = mbe_pkg::ST_MUL_Y;
      end
      mbe_pkg::ST_MUL_Y: begin
        mul_a      = $signed({22'd0, row_q});
        mul_b      = $signed({7'd0, cfg.y_step});
        state_next = mbe_pkg::ST_CI_WB;
      end
      mbe_pkg::ST_CI_WB: begin
        state_next = mbe_pkg::ST_SQ_X;
      end
      mbe_pkg::ST_SQ_X: begin
        mul_a = zx;
        mul_b = zx;
        if (at_limit) begin
          state_next = mbe_pkg::ST_IDLE;
        end else begin
          state_next = mbe_pkg::ST_SQ_Y;
        end
      end
      mbe_pkg::ST_SQ_Y: begin
        mul_a      = zy;
        mul_b      = zy;
        state_next = mbe_pkg::ST_PROD;
      end
      mbe_pkg::ST_PROD: begin
        mul_a = zx;
        mul_b = zy;
        if (escaped) begin
          state_next = mbe_pkg::ST_IDLE;
        end else begin
          state_next = mbe_pkg::ST_UPD;
        end
      end
      mbe_pkg::ST_UPD: begin
        state_next = mbe_pkg::ST_SQ_X;
      end
      default: begin
        state_next = mbe_pkg::ST_IDLE;
      end
    endcase
  end

  // result strobe: registered, high in the cycle after the loop ends
  always_ff @(posedge clk) begin
    if (rst) begin
      fin <= 1'b0;
    end else begin
      fin <= ((state == mbe_pkg::ST_SQ_X) && at_limit) ||
             ((state == mbe_pkg::ST_PROD) && escaped);
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      mbe_pkg::ST_IDLE: begin
        col_q <= column;
        row_q <= row;
        count <= 16'd1;
        zx    <= 32'sd0;
        zy    <= 32'sd0;
      end
      mbe_pkg::ST_MUL_Y: cr <= mbe_pkg::sat32(cr_sum);
      mbe_pkg::ST_CI_WB: ci <= mbe_pkg::sat32(ci_sum);
      mbe_pkg::ST_SQ_Y:  xx <= sq_val;
      mbe_pkg::ST_PROD:  yy <= sq_val;
      mbe_pkg::ST_UPD: begin
        zx    <= mbe_pkg::sat32(zx_sum);
        zy    <= mbe_pkg::sat32(zy_sum);
        count <= count + 16'd1;
      end
      default: ;
    endcase
  end

  // the strobe cycle sits in idle; busy stays high through it to hold off a new pixel
  assign busy       = (state != mbe_pkg::ST_IDLE) || fin;
  assign done       = fin;
  assign iterations = count;
  assign c_real     = cr;
  assign c_imag     = ci;

endmodule

`default_nettype wire

// ===== rtl/mandelbrot_escape_time.sv =====
// ----------------------------------------------------------------------------
// mandelbrot_escape_time
// Escape-time engine for one pixel of the Mandelbrot set in Q4.28.
// ----------------------------------------------------------------------------
// Usage:
//   Pulse start with column and row while busy is low; the word is taken at
//   that edge and busy rises. The pixel maps to c = (x_origin + column*x_step,
//   y_top - row*y_step), saturated to 32 bits, and z = z*z + c runs from 0.
//   done is high for exactly one cycle with iterations, c_real and c_imag;
//   the receiver has no way to stall, so it must take the word then.
//   iterations is one more than the completed steps. After accept the pixel
//   is mapped to c with two products; each step then runs three products
//   through the one shared 32x32 multiplier plus the update, with the limit
//   checked as a step starts and the escape test after both squares. busy
//   stays high until done has dropped, so one pixel is in flight at a time.
//   Configuration: APB, words at 0x00 x_origin, 0x04 y_top, 0x08 x_step,
//   0x0C y_step, 0x10 max_iterations; write only while idle.
//   Reset (rst, synchronous) returns to idle and loads the default window
//   (-2.5 .. , +1.0) and an iteration limit of 1000.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module mandelbrot_escape_time (
  input  wire logic                       clk,
  input  wire logic                       rst,
  // pixel command
  input  wire logic                       start,
  input  wire logic [9:0]                 column,
  input  wire logic [9:0]                 row,
  output logic                            busy,
  // result
  output logic                            done,
  output logic [15:0]                     iterations,
  output logic signed [31:0]              c_real,
  output logic signed [31:0]              c_imag,
  // configuration
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [mbe_pkg::ADDR_W-1:0] paddr,
  input  wire logic [31:0]                pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);

  mbe_pkg::cfg_t cfg;
  logic          count_ok;

  mbe_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  mbe_seq u_seq (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .start      (start),
    .column     (column),
    .row        (row),
    .busy       (busy),
    .done       (done),
    .iterations (iterations),
    .c_real     (c_real),
    .c_imag     (c_imag)
  );

  // count lies in 1 .. max_iterations, or is 1 for a zero limit
  assign count_ok = (iterations != 16'd0) &&
                    ((iterations <= cfg.max_iter) || (iterations == 16'd1));

  // checks
  `MBE_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted word did not raise busy")
  `MBE_ASSERT_NEXT(a_done_pulse, done, !done, "done held longer than one cycle")
  `MBE_ASSERT_NOW(a_done_busy, done, busy, "done outside a busy window")
  `MBE_ASSERT_NOW(a_count_range, done, count_ok, "iteration count out of range")

endmodule

`default_nettype wire
